// ===== rtl/gcdva_pkg.sv =====
package gcdva_pkg;

  localparam int unsigned LEN_W   = 20;
  localparam int unsigned DEPTH_W = 26;
  localparam int unsigned PORO_W  = 16;
  localparam int unsigned VOL_W   = 60;
  localparam int unsigned OIDX_W  = 24;
  localparam int unsigned DIM_W   = 17;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_THERMAL_MODE     = 3'd0;
  localparam logic [2:0] REG_COLS_X           = 3'd1;
  localparam logic [2:0] REG_ROWS_Y           = 3'd2;
  localparam logic [2:0] REG_PORO_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_VOLUME_THRESHOLD = 3'd4;

  typedef struct packed {
    logic               first_cell;
    logic [LEN_W-1:0]   size_x;
    logic [LEN_W-1:0]   size_y;
    logic [LEN_W-1:0]   thickness;
    logic [DEPTH_W-1:0] top_depth;
    logic               cell_enabled;
    logic [PORO_W-1:0]  porosity;
  } in_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] centre_depth;
    logic [VOL_W-1:0]   cell_volume;
    logic               is_active;
    logic [OIDX_W-1:0]  active_index;
    logic               is_fluid;
    logic [OIDX_W-1:0]  fluid_index;
  } out_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [LEN_W-1:0]   thickness;
  } plane_entry_t;

endpackage

// ===== rtl/gcdva_plane_mem.sv =====
module gcdva_plane_mem
  import gcdva_pkg::*;
#(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  plane_entry_t    wdata,
  input  logic [AW-1:0]   raddr,
  output plane_entry_t    rdata
);

  plane_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/grid_cell_depth_volume_activity_top.sv =====
// Grid cell depth, volume and activity classifier.
// Input beats carry one grid cell each, in x, then y, then z order; a beat
// with first_cell set starts a new grid and clears the running indices.
// Each input beat yields exactly one output beat with the centre depth,
// the cell volume, the active and fluid flags and their compacted indices.
// Settings are written through the APB port (64-bit data, register i at byte
// address 8*i), by the user only while no cell is in flight; not enforced.
// An accepted cell passes through S_READ, S_DEPTH and S_FIN, which cover the
// read, update and write back of the plane memory and the split 60-bit volume
// product; a new cell is taken only in S_IDLE, after the last has left S_FIN.
// The output register holds one finished beat; the next cell is taken while
// it waits, and that cell stalls in its last step until out_ready frees it.
// Reset returns the settings to their defaults, clears the indices and the
// plane position; the plane memory is not cleared, since every entry is
// written in the first layer before any later layer reads it.
module grid_cell_depth_volume_activity_top
  import gcdva_pkg::*;
#(
  parameter int unsigned PLANE_CELLS = 65536,
  parameter int unsigned INDEX_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW     = (PLANE_CELLS > 1) ? $clog2(PLANE_CELLS) : 1;
  localparam int unsigned LW     = $clog2(PLANE_CELLS + 1);
  localparam int unsigned PROD_W = 2 * DIM_W;
  localparam int unsigned EXT_W  = (INDEX_BITS > OIDX_W) ? INDEX_BITS : OIDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DEPTH = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  // Configuration registers.
  logic               thermal_mode;
  logic [DIM_W-1:0]   cols_x;
  logic [DIM_W-1:0]   rows_y;
  logic [PORO_W-1:0]  poro_threshold;
  logic [VOL_W-1:0]   volume_threshold;
  logic [LW-1:0]      plane_len;

  logic [2:0]         reg_idx;
  logic               cfg_wr;
  logic [DIM_W-1:0]   cx_eff;
  logic [DIM_W-1:0]   ry_eff;
  logic [PROD_W-1:0]  len_prod;

  // Sequencer and running state.
  logic [1:0]             state;
  in_t                    item;
  logic [AW-1:0]          plane_position;
  logic                   in_first_layer;
  logic [INDEX_BITS-1:0]  active_counter;
  logic [INDEX_BITS-1:0]  fluid_counter;
  logic [AW-1:0]          cur_pos;
  logic                   cur_first;

  logic [AW-1:0]          pos_eff;
  logic                   first_eff;
  logic [LW-1:0]          pos_inc;

  // Datapath registers.
  logic [2*LEN_W-1:0]     area;
  logic [2*LEN_W-1:0]     prod_lo;
  logic [2*LEN_W-1:0]     prod_hi;
  logic [DEPTH_W-1:0]     depth_reg;

  logic                   mem_we;
  plane_entry_t           mem_wdata;
  plane_entry_t           mem_rdata;
  logic [DEPTH_W:0]       depth_sum;
  logic [DEPTH_W-1:0]     depth_sat;

  logic [VOL_W-1:0]       vol;
  logic                   vol_ok;
  logic                   poro_ok;
  logic                   active;
  logic                   fluid;
  logic                   fin_go;
  logic [EXT_W-1:0]       aidx_ext;
  logic [EXT_W-1:0]       fidx_ext;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thermal_mode     <= 1'b0;
      cols_x           <= DIM_W'(1);
      rows_y           <= DIM_W'(1);
      poro_threshold   <= PORO_W'(1);
      volume_threshold <= VOL_W'(1074);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THERMAL_MODE:     thermal_mode     <= pwdata[0];
        REG_COLS_X:           cols_x           <= pwdata[DIM_W-1:0];
        REG_ROWS_Y:           rows_y           <= pwdata[DIM_W-1:0];
        REG_PORO_THRESHOLD:   poro_threshold   <= pwdata[PORO_W-1:0];
        REG_VOLUME_THRESHOLD: volume_threshold <= pwdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THERMAL_MODE:     prdata = APB_DW'(thermal_mode);
      REG_COLS_X:           prdata = APB_DW'(cols_x);
      REG_ROWS_Y:           prdata = APB_DW'(rows_y);
      REG_PORO_THRESHOLD:   prdata = APB_DW'(poro_threshold);
      REG_VOLUME_THRESHOLD: prdata = APB_DW'(volume_threshold);
      default:              prdata = '0;
    endcase
  end

  // A zero dimension counts as one; the plane length saturates at the
  // memory depth and is registered from the dimension registers.
  assign cx_eff   = (cols_x == '0) ? DIM_W'(1) : cols_x;
  assign ry_eff   = (rows_y == '0) ? DIM_W'(1) : rows_y;
  assign len_prod = PROD_W'(cx_eff) * PROD_W'(ry_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_len <= LW'(1);
    end else if (len_prod > PROD_W'(PLANE_CELLS)) begin
      plane_len <= LW'(PLANE_CELLS);
    end else begin
      plane_len <= LW'(len_prod);
    end
  end

  // ---------------------------------------------------------- sequencer
  assign in_ready = (state == S_IDLE);
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  // Position of this cell after a grid restart and after a wrap past the
  // plane end.
  always_comb begin
    pos_eff   = item.first_cell ? '0 : plane_position;
    first_eff = item.first_cell ? 1'b1 : in_first_layer;
    if (LW'(pos_eff) >= plane_len) begin
      pos_eff   = '0;
      first_eff = 1'b0;
    end
    pos_inc = LW'(pos_eff) + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_READ;
        S_READ:  state <= S_DEPTH;
        S_DEPTH: state <= S_FIN;
        S_FIN:   if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (state == S_READ) begin
      cur_pos   <= pos_eff;
      cur_first <= first_eff;
      area      <= (2*LEN_W)'(item.size_x) * (2*LEN_W)'(item.size_y);
    end
    if (state == S_DEPTH) begin
      depth_reg <= depth_sat;
      prod_lo   <= (2*LEN_W)'(area[LEN_W-1:0]) * (2*LEN_W)'(item.thickness);
      prod_hi   <= (2*LEN_W)'(area[2*LEN_W-1:LEN_W]) * (2*LEN_W)'(item.thickness);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_position <= '0;
      in_first_layer <= 1'b1;
      active_counter <= '0;
      fluid_counter  <= '0;
    end else begin
      if (state == S_READ) begin
        if (pos_inc >= plane_len) begin
          plane_position <= '0;
          in_first_layer <= 1'b0;
        end else begin
          plane_position <= AW'(pos_inc);
          in_first_layer <= first_eff;
        end
        if (item.first_cell) begin
          active_counter <= '0;
          fluid_counter  <= '0;
        end
      end
      if (fin_go) begin
        if (active) active_counter <= active_counter + INDEX_BITS'(1);
        if (fluid)  fluid_counter  <= fluid_counter + INDEX_BITS'(1);
      end
    end
  end

  // --------------------------------------------------------- plane store
  gcdva_plane_mem #(
    .DEPTH (PLANE_CELLS),
    .AW    (AW)
  ) u_plane (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_pos),
    .wdata (mem_wdata),
    .raddr (pos_eff),
    .rdata (mem_rdata)
  );

  // The plane keeps the centre depth and thickness of the cell above, so the
  // next layer's centre is that depth plus both half thicknesses.
  always_comb begin
    if (cur_first) begin
      depth_sum = (DEPTH_W+1)'(item.top_depth) + (DEPTH_W+1)'(item.thickness);
    end else begin
      depth_sum = (DEPTH_W+1)'(mem_rdata.depth) + (DEPTH_W+1)'(mem_rdata.thickness)
                + (DEPTH_W+1)'(item.thickness);
    end
    depth_sat = depth_sum[DEPTH_W] ? '1 : depth_sum[DEPTH_W-1:0];
  end

  assign mem_we              = (state == S_DEPTH);
  assign mem_wdata.depth     = depth_sat;
  assign mem_wdata.thickness = item.thickness;

  // ------------------------------------------------------ classification
  assign vol     = {prod_hi, {LEN_W{1'b0}}} + VOL_W'(prod_lo);
  assign vol_ok  = (vol >= volume_threshold);
  assign poro_ok = (item.porosity >= poro_threshold);

  always_comb begin
    if (thermal_mode) begin
      active = item.cell_enabled && vol_ok;
      fluid  = active && poro_ok;
    end else begin
      active = item.cell_enabled && vol_ok && poro_ok;
      fluid  = active;
    end
  end

  assign aidx_ext = EXT_W'(active_counter);
  assign fidx_ext = EXT_W'(fluid_counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data.centre_depth <= depth_reg;
      out_data.cell_volume  <= vol;
      out_data.is_active    <= active;
      out_data.active_index <= active ? aidx_ext[OIDX_W-1:0] : '0;
      out_data.is_fluid     <= fluid;
      out_data.fluid_index  <= fluid ? fidx_ext[OIDX_W-1:0] : '0;
    end
  end

endmodule

// ===== verif/grid_cell_depth_volume_activity_top_test.sv =====
`timescale 1ns / 100ps

module grid_cell_depth_volume_activity_top_test;
  import gcdva_pkg::*;

  localparam int unsigned PLANE_CELLS  = 65536;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_CELLS = 1600;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned DSUM_W       = DEPTH_W + 2;
  localparam logic [DEPTH_W-1:0] DEPTH_CEIL = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX    = '1;
  localparam logic [VOL_W-1:0]   VOL_MAX    = '1;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_pattern_e;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  grid_cell_depth_volume_activity_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // Expected behavior: one plane of depths and thicknesses plus the settings.
  logic [DEPTH_W-1:0] depth_plane [PLANE_CELLS];
  logic [LEN_W-1:0]   thick_plane [PLANE_CELLS];
  logic [OIDX_W-1:0]  active_count;
  logic [OIDX_W-1:0]  fluid_count;
  int unsigned        plane_pos;
  bit                 top_layer;
  bit                 mode_thermal;
  logic [DIM_W-1:0]   num_cols;
  logic [DIM_W-1:0]   num_rows;
  logic [PORO_W-1:0]  poro_min;
  logic [VOL_W-1:0]   vol_min;
  out_t               cell_results_due [$];

  int unsigned fault_count;
  int unsigned cells_checked;
  int unsigned active_seen;
  int unsigned fluid_seen;
  int unsigned ceiling_hits;
  int unsigned settings_used;
  int unsigned random_sent;
  int unsigned burst_left;
  bit          valid_held;
  int unsigned quiet_cycles;
  rx_pattern_e rx_pattern;
  int unsigned rx_run;
  out_t        due_cell;

  task automatic report_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    if (fault_count < 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
    fault_count++;
  endtask

  task automatic classify_cell(input in_t c);
    out_t            r;
    longint unsigned cx, ry, span;
    logic [DSUM_W-1:0] d;
    bit              poro_ok, vol_ok;
    cx = (num_cols == 0) ? 64'd1 : 64'(num_cols);
    ry = (num_rows == 0) ? 64'd1 : 64'(num_rows);
    span = (cx * ry > 64'(PLANE_CELLS)) ? 64'(PLANE_CELLS) : cx * ry;
    if (c.first_cell) begin
      plane_pos = 0;
      top_layer = 1'b1;
      active_count = '0;
      fluid_count = '0;
    end
    if (plane_pos >= span) begin
      plane_pos = 0;
      top_layer = 1'b0;
    end
    // Half a Q10.10 thickness is its raw value in Q15.11, so the sums add raw codes.
    if (top_layer) begin
      d = DSUM_W'(c.top_depth) + DSUM_W'(c.thickness);
    end else begin
      d = DSUM_W'(depth_plane[plane_pos]) + DSUM_W'(thick_plane[plane_pos])
          + DSUM_W'(c.thickness);
    end
    r.centre_depth = (d > DEPTH_CEIL) ? DEPTH_CEIL : d[DEPTH_W-1:0];
    depth_plane[plane_pos] = r.centre_depth;
    thick_plane[plane_pos] = c.thickness;
    r.cell_volume = VOL_W'(c.size_x) * VOL_W'(c.size_y) * VOL_W'(c.thickness);
    poro_ok = c.porosity >= poro_min;
    vol_ok = r.cell_volume >= vol_min;
    // In isothermal mode porosity gates activity, so fluid follows active.
    r.is_active = c.cell_enabled && vol_ok && (mode_thermal || poro_ok);
    r.is_fluid = r.is_active && poro_ok;
    r.active_index = r.is_active ? active_count : '0;
    r.fluid_index = r.is_fluid ? fluid_count : '0;
    if (r.is_active) active_count++;
    if (r.is_fluid) fluid_count++;
    plane_pos++;
    if (plane_pos >= span) begin
      plane_pos = 0;
      top_layer = 1'b0;
    end
    if (r.is_active) active_seen++;
    if (r.is_fluid) fluid_seen++;
    if (r.centre_depth == DEPTH_CEIL) ceiling_hits++;
    cell_results_due.insert(cell_results_due.size(), r);
  endtask

  task automatic send_cell(input in_t c);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    classify_cell(c);
    if (burst_left != 0) begin
      burst_left--;
      valid_held = 1'b1;
    end else begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic settle();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (cell_results_due.size() != 0) @(posedge clk);
  endtask

  // Write one register, then read it back over the same port.
  task automatic program_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_THERMAL_MODE:     mode_thermal = value[0];
      REG_COLS_X:           num_cols = value[DIM_W-1:0];
      REG_ROWS_Y:           num_rows = value[DIM_W-1:0];
      REG_PORO_THRESHOLD:   poro_min = value[PORO_W-1:0];
      REG_VOLUME_THRESHOLD: vol_min = value[VOL_W-1:0];
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== value) report_fault("register readback", value, readback);
  endtask

  function automatic in_t make_cell(input bit first, input logic [LEN_W-1:0] sx,
                                    input logic [LEN_W-1:0] sy, input logic [LEN_W-1:0] dz,
                                    input logic [DEPTH_W-1:0] top, input bit en,
                                    input logic [PORO_W-1:0] poro);
    in_t c;
    c.first_cell = first;
    c.size_x = sx;
    c.size_y = sy;
    c.thickness = dz;
    c.top_depth = top;
    c.cell_enabled = en;
    c.porosity = poro;
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 5))
      0, 1:    return LEN_W'($urandom);
      2, 3:    return LEN_W'($urandom_range(0, 4095));
      4:       return LEN_W'($urandom_range(900, 1200));
      default: return ($urandom_range(0, 1) != 0) ? LEN_MAX : '0;
    endcase
  endfunction

  function automatic in_t random_cell(input bit first);
    logic [DEPTH_W-1:0] top;
    top = ($urandom_range(0, 7) == 0) ? DEPTH_W'($urandom)
                                      : DEPTH_W'($urandom_range(0, 1 << 20));
    return make_cell(first, pick_length(), pick_length(), pick_length(), top,
                     $urandom_range(0, 7) != 0, PORO_W'($urandom));
  endfunction

  // Default settings: a one-cell plane, so every later cell stacks on the one above.
  task automatic test_field_extremes();
    send_cell(make_cell(1'b1, '0, '0, '0, '0, 1'b1, '0));
    send_cell(make_cell(1'b0, LEN_MAX, LEN_MAX, LEN_MAX, DEPTH_CEIL, 1'b1, '1));
    send_cell(make_cell(1'b1, LEN_MAX, LEN_MAX, LEN_MAX, DEPTH_CEIL, 1'b1, '1));
    // Volume exactly at the threshold and porosity exactly at its threshold.
    send_cell(make_cell(1'b0, 20'd2, 20'd3, 20'd179, '0, 1'b1, 16'd1));
    send_cell(make_cell(1'b0, 20'd29, 20'd37, 20'd1, '0, 1'b1, '1));
    send_cell(make_cell(1'b0, LEN_MAX, LEN_MAX, LEN_MAX, '0, 1'b0, '1));
    send_cell(make_cell(1'b0, LEN_MAX, LEN_MAX, LEN_MAX, '0, 1'b1, '0));
  endtask

  task automatic test_register_settings();
    settle();
    program_reg(REG_THERMAL_MODE, 64'd1);
    program_reg(REG_COLS_X, 64'd0);
    program_reg(REG_ROWS_Y, 64'd0);
    program_reg(REG_PORO_THRESHOLD, 64'hFFFF);
    program_reg(REG_VOLUME_THRESHOLD, 64'd0);
    settings_used++;
    send_cell(make_cell(1'b1, '0, '0, '0, 26'd5000, 1'b1, 16'hFFFE));
    send_cell(make_cell(1'b0, 20'd1024, 20'd2048, 20'd512, '0, 1'b1, 16'hFFFF));
    send_cell(make_cell(1'b0, 20'd1024, 20'd2048, 20'd512, '0, 1'b0, 16'hFFFF));
    settle();
    program_reg(REG_VOLUME_THRESHOLD, APB_DW'(VOL_MAX));
    settings_used++;
    send_cell(make_cell(1'b0, LEN_MAX, LEN_MAX, LEN_MAX, '0, 1'b1, 16'hFFFF));
  endtask

  task automatic test_plane_wrap();
    settle();
    program_reg(REG_THERMAL_MODE, 64'd0);
    program_reg(REG_COLS_X, 64'd2);
    program_reg(REG_ROWS_Y, 64'd2);
    program_reg(REG_PORO_THRESHOLD, 64'h4000);
    program_reg(REG_VOLUME_THRESHOLD, 64'd1 << 20);
    settings_used++;
    for (int i = 0; i < 10; i++) send_cell(random_cell(i == 0));
  endtask

  // The previous grid stops mid-layer; shrinking the plane puts the position past its end.
  task automatic test_position_past_plane();
    settle();
    program_reg(REG_COLS_X, 64'd1);
    program_reg(REG_ROWS_Y, 64'd1);
    settings_used++;
    for (int i = 0; i < 3; i++) send_cell(random_cell(1'b0));
  endtask

  task automatic test_random_grids();
    int unsigned cols, rows, cells;
    logic [VOL_W-1:0] vmin;
    while (random_sent < RANDOM_CELLS) begin
      settle();
      case ($urandom_range(0, 11))
        0: begin
          cols = 65536;
          rows = $urandom_range(1, 3);
          cells = 40;
        end
        1: begin
          cols = $urandom_range(0, 3);
          rows = 65536;
          cells = 40;
        end
        2: begin
          cols = 65536;
          rows = 65536;
          cells = 30;
        end
        default: begin
          cols = $urandom_range(0, 7);
          rows = $urandom_range(0, 5);
          cells = $urandom_range(60, 200);
        end
      endcase
      vmin = VOL_W'({$urandom, $urandom} >> $urandom_range(4, 63));
      program_reg(REG_THERMAL_MODE, APB_DW'($urandom_range(0, 1)));
      program_reg(REG_COLS_X, APB_DW'(cols));
      program_reg(REG_ROWS_Y, APB_DW'(rows));
      program_reg(REG_PORO_THRESHOLD, APB_DW'(PORO_W'($urandom)));
      program_reg(REG_VOLUME_THRESHOLD, APB_DW'(vmin));
      settings_used++;
      for (int i = 0; i < cells; i++) begin
        send_cell(random_cell(i == 0 || $urandom_range(0, 79) == 0));
        random_sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_pattern <= RX_OPEN;
      rx_run <= 0;
    end else begin
      if (rx_run == 0) begin
        rx_pattern <= rx_pattern_e'($urandom_range(0, 2));
        rx_run <= $urandom_range(50, 300);
      end else begin
        rx_run <= rx_run - 1;
      end
      case (rx_pattern)
        RX_OPEN:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (cell_results_due.size() == 0) begin
        report_fault("unexpected result beat", '0, 64'(out_data.centre_depth));
      end else begin
        due_cell = cell_results_due.pop_front();
        if (out_data.centre_depth !== due_cell.centre_depth)
          report_fault("centre_depth", 64'(due_cell.centre_depth), 64'(out_data.centre_depth));
        if (out_data.cell_volume !== due_cell.cell_volume)
          report_fault("cell_volume", 64'(due_cell.cell_volume), 64'(out_data.cell_volume));
        if (out_data.is_active !== due_cell.is_active)
          report_fault("is_active", 64'(due_cell.is_active), 64'(out_data.is_active));
        if (out_data.active_index !== due_cell.active_index)
          report_fault("active_index", 64'(due_cell.active_index), 64'(out_data.active_index));
        if (out_data.is_fluid !== due_cell.is_fluid)
          report_fault("is_fluid", 64'(due_cell.is_fluid), 64'(out_data.is_fluid));
        if (out_data.fluid_index !== due_cell.fluid_index)
          report_fault("fluid_index", 64'(due_cell.fluid_index), 64'(out_data.fluid_index));
        cells_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    active_count = '0;
    fluid_count = '0;
    plane_pos = 0;
    top_layer = 1'b1;
    mode_thermal = 1'b0;
    num_cols = 1;
    num_rows = 1;
    poro_min = 1;
    vol_min = 1074;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_register_settings();
    test_plane_wrap();
    test_position_past_plane();
    test_random_grids();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d cells under %0d register settings: %0d active, %0d fluid,",
             cells_checked, settings_used, active_seen, fluid_seen);
    $display("%0d centre depths at the ceiling, %0d mismatches.", ceiling_hits, fault_count);
    if (fault_count == 0 && cell_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gcdva_pkg.sv
rtl/gcdva_plane_mem.sv
rtl/grid_cell_depth_volume_activity_top.sv
verif/grid_cell_depth_volume_activity_top_test.sv
